>>> sv/cll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cll_pkg
// Types, operation codes and sequencer states of the circular link engine.
// ----------------------------------------------------------------------------
package cll_pkg;

    localparam int unsigned ID_W    = 12;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned ID_MAX  = 4095;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

    localparam logic [2:0] OP_APPEND     = 3'd0;
    localparam logic [2:0] OP_INS_AFTER  = 3'd1;
    localparam logic [2:0] OP_INS_BEFORE = 3'd2;
    localparam logic [2:0] OP_RM_NEXT    = 3'd3;
    localparam logic [2:0] OP_RM_PREV    = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0] new_id;
        logic [ID_W-1:0] anchor_id;
        logic [2:0]      op;
    } cmd_t;

    typedef struct packed {
        logic            status;
        logic [ID_W-1:0] neighbour_id;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_FIRST,
        S_RD_HEAD,
        S_APP_W1,
        S_APP_W2,
        S_RD_ANC,
        S_SEL,
        S_INS_RX,
        S_INS_W1,
        S_INS_RY,
        S_INS_W2,
        S_RM_RD,
        S_RM_W1,
        S_RM_RN,
        S_RM_W2,
        S_RESP
    } state_t;

endpackage
`default_nettype wire

>>> sv/cll_link_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cll_link_ram
// Single-port link memory with registered read data.
// ----------------------------------------------------------------------------
module cll_link_ram
    import cll_pkg::*;
#(
    parameter int unsigned DEPTH = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [ID_W-1:0]          wdata,
    output logic      [ID_W-1:0]          rdata
);

    logic [ID_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

>>> sv/cll_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cll_ctrl
// Command sequencer: steps every link read and write through the two
// single-port link memories in order, and keeps the ring head and count.
// ----------------------------------------------------------------------------
module cll_ctrl
    import cll_pkg::*;
#(
    parameter int unsigned NUM_IDS = 4096
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire cmd_t                       cmd,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    output rsp_t                            rsp,
    output logic                            next_we,
    output logic      [$clog2(NUM_IDS)-1:0] next_addr,
    output logic      [ID_W-1:0]            next_wdata,
    input  wire logic [ID_W-1:0]            next_rdata,
    output logic                            prev_we,
    output logic      [$clog2(NUM_IDS)-1:0] prev_addr,
    output logic      [ID_W-1:0]            prev_wdata,
    input  wire logic [ID_W-1:0]            prev_rdata
);

    localparam int unsigned ADDR_W = $clog2(NUM_IDS);

    function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_W-1:0] id);
        logic [31:0] v;
        v = 32'(id);
        for (int k = ID_W - 1; k >= 0; k--)
        begin
            if (((64'(NUM_IDS) << k) <= 64'(ID_MAX)) && (v >= 32'(64'(NUM_IDS) << k)))
            begin
                v = v - 32'(64'(NUM_IDS) << k);
            end
        end
        return v[ADDR_W-1:0];
    endfunction

    state_t             state_reg,  state_next;
    logic [2:0]         op_reg,     op_next;
    logic [ID_W-1:0]    anchor_reg, anchor_next;
    logic [ID_W-1:0]    item_reg,   item_next;
    logic [ID_W-1:0]    at_reg,     at_next;
    logic [ID_W-1:0]    p_reg,      p_next;
    logic [ID_W-1:0]    nb_reg,     nb_next;
    logic               status_reg, status_next;
    logic [ID_W-1:0]    head_reg,   head_next;
    logic [COUNT_W-1:0] count_reg,  count_next;

    logic [COUNT_W-1:0] count_up;
    logic [COUNT_W-1:0] count_down;
    logic               refuse;

    assign count_up   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign count_down = (count_reg != '0) ? count_reg - 1'b1 : count_reg;

    always_comb
    begin
        refuse = 1'b0;
        unique case (cmd.op) inside
            OP_INS_AFTER, OP_INS_BEFORE: refuse = (count_reg == '0);
            OP_RM_NEXT, OP_RM_PREV:      refuse = (count_reg < COUNT_W'(2));
            default:                     refuse = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op) inside
                        OP_APPEND:
                            state_next = (count_reg == '0) ? S_APP_FIRST : S_RD_HEAD;
                        OP_INS_AFTER, OP_INS_BEFORE, OP_RM_NEXT, OP_RM_PREV:
                            state_next = refuse ? S_RESP : S_RD_ANC;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_APP_FIRST: state_next = S_IDLE;
            S_RD_HEAD:   state_next = S_APP_W1;
            S_APP_W1:    state_next = S_APP_W2;
            S_APP_W2:    state_next = S_IDLE;
            S_RD_ANC:    state_next = S_SEL;
            S_SEL:
                state_next = ((op_reg == OP_INS_AFTER) || (op_reg == OP_INS_BEFORE))
                             ? S_INS_RX : S_RM_RD;
            S_INS_RX:    state_next = S_INS_W1;
            S_INS_W1:    state_next = S_INS_RY;
            S_INS_RY:    state_next = S_INS_W2;
            S_INS_W2:    state_next = S_RESP;
            S_RM_RD:     state_next = S_RM_W1;
            S_RM_W1:     state_next = S_RM_RN;
            S_RM_RN:     state_next = S_RM_W2;
            S_RM_W2:     state_next = S_RESP;
            S_RESP:      state_next = rsp_ready ? S_IDLE : S_RESP;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        anchor_next = anchor_reg;
        item_next   = item_reg;
        at_next     = at_reg;
        p_next      = p_reg;
        nb_next     = nb_reg;
        status_next = status_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        next_we     = 1'b0;
        prev_we     = 1'b0;
        next_addr   = to_addr(at_reg);
        prev_addr   = to_addr(at_reg);
        next_wdata  = item_reg;
        prev_wdata  = item_reg;
        cmd_ready   = 1'b0;
        rsp_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready   = 1'b1;
                op_next     = cmd.op;
                anchor_next = cmd.anchor_id;
                item_next   = cmd.new_id;
                nb_next     = '0;
                status_next = refuse;
            end
            S_APP_FIRST:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                next_addr  = to_addr(anchor_reg);
                prev_addr  = to_addr(anchor_reg);
                next_wdata = anchor_reg;
                prev_wdata = anchor_reg;
                head_next  = anchor_reg;
                count_next = count_up;
            end
            S_RD_HEAD:
            begin
                prev_addr = to_addr(head_reg);
            end
            S_APP_W1:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                next_addr  = to_addr(prev_rdata);
                next_wdata = anchor_reg;
                prev_addr  = to_addr(anchor_reg);
                prev_wdata = prev_rdata;
            end
            S_APP_W2:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                next_addr  = to_addr(anchor_reg);
                next_wdata = head_reg;
                prev_addr  = to_addr(head_reg);
                prev_wdata = anchor_reg;
                count_next = count_up;
            end
            S_RD_ANC:
            begin
                next_addr = to_addr(anchor_reg);
                prev_addr = to_addr(anchor_reg);
            end
            S_SEL:
            begin
                unique case (op_reg) inside
                    OP_INS_AFTER:
                    begin
                        at_next = anchor_reg;
                        nb_next = next_rdata;
                    end
                    OP_RM_NEXT:
                    begin
                        at_next = next_rdata;
                        nb_next = next_rdata;
                    end
                    OP_INS_BEFORE, OP_RM_PREV:
                    begin
                        at_next = prev_rdata;
                        nb_next = prev_rdata;
                    end
                    default:
                    begin
                        at_next = at_reg;
                    end
                endcase
            end
            S_INS_RX, S_INS_RY, S_RM_RN:
            begin
                next_addr = to_addr(at_reg);
            end
            S_INS_W1:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                next_addr  = to_addr(item_reg);
                next_wdata = next_rdata;
                prev_addr  = to_addr(item_reg);
                prev_wdata = at_reg;
            end
            S_INS_W2:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                next_addr  = to_addr(at_reg);
                next_wdata = item_reg;
                prev_addr  = to_addr(next_rdata);
                prev_wdata = item_reg;
                count_next = count_up;
            end
            S_RM_RD:
            begin
                next_addr = to_addr(at_reg);
                prev_addr = to_addr(at_reg);
            end
            S_RM_W1:
            begin
                next_we    = 1'b1;
                next_addr  = to_addr(prev_rdata);
                next_wdata = next_rdata;
                p_next     = prev_rdata;
            end
            S_RM_W2:
            begin
                prev_we    = 1'b1;
                prev_addr  = to_addr(next_rdata);
                prev_wdata = p_reg;
                count_next = count_down;
                if (at_reg == head_reg)
                begin
                    head_next = next_rdata;
                end
            end
            S_RESP:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                rsp_valid = 1'b0;
            end
        endcase
    end

    assign rsp.neighbour_id = nb_reg;
    assign rsp.status       = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        anchor_reg <= anchor_next;
        item_reg   <= item_next;
        at_reg     <= at_next;
        p_reg      <= p_next;
        nb_reg     <= nb_next;
        status_reg <= status_next;
    end

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (rsp.neighbour_id == '0))
        else $error("refused transaction carries a neighbour id");

    a_rm_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RM_RD) |-> (count_reg >= COUNT_W'(2)))
        else $error("removal started on a ring below two ids");

    a_ins_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_W2) |=>
            ((count_reg == $past(count_reg) + 1'b1) || ($past(count_reg) == COUNT_MAX)))
        else $error("insertion did not advance the ring count");

    a_head_moves: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != S_APP_FIRST) && (state_reg != S_RM_W2)) |=> $stable(head_reg))
        else $error("ring head moved outside first append or removal");

endmodule
`default_nettype wire

>>> sv/circular_linked_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_linked_list_engine
// Circular doubly linked ring of ids kept in next and prev link memories.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata bits (lowest first)
// s_axis    in   op[2:0], anchor_id[14:3], new_id[26:15], zero fill to 32
// m_axis    out  neighbour_id[11:0], status[12], zero fill to 16
//
// Append on an empty ring writes the first id; else it reads the head, then writes.
// Insert and remove read the anchor, then read and write; refusals go straight to the response.
// Each link memory has one port with a registered read, so every link read
// and link write takes a sequencer step of its own.
// Reset clears ring head, count, sequencer state and output valid; link entries are undefined until
// written. A result waits in the output register while the next command runs.
// ----------------------------------------------------------------------------
module circular_linked_list_engine
    import cll_pkg::*;
#(
    parameter int unsigned NUM_IDS = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // op, anchor_id, new_id
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata    // neighbour_id, status
);

    localparam int unsigned ADDR_W = $clog2(NUM_IDS);

    cmd_t              cmd;
    rsp_t              rsp;
    logic              rsp_valid;
    logic              rsp_ready;
    logic              next_we;
    logic [ADDR_W-1:0] next_addr;
    logic [ID_W-1:0]   next_wdata;
    logic [ID_W-1:0]   next_rdata;
    logic              prev_we;
    logic [ADDR_W-1:0] prev_addr;
    logic [ID_W-1:0]   prev_wdata;
    logic [ID_W-1:0]   prev_rdata;

    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg;

    assign cmd.op        = s_axis_tdata[2:0];
    assign cmd.anchor_id = s_axis_tdata[14:3];
    assign cmd.new_id    = s_axis_tdata[26:15];

    cll_ctrl #(
        .NUM_IDS (NUM_IDS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (s_axis_tvalid),
        .cmd_ready  (s_axis_tready),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .next_we    (next_we),
        .next_addr  (next_addr),
        .next_wdata (next_wdata),
        .next_rdata (next_rdata),
        .prev_we    (prev_we),
        .prev_addr  (prev_addr),
        .prev_wdata (prev_wdata),
        .prev_rdata (prev_rdata)
    );

    cll_link_ram #(
        .DEPTH (NUM_IDS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .addr  (next_addr),
        .wdata (next_wdata),
        .rdata (next_rdata)
    );

    cll_link_ram #(
        .DEPTH (NUM_IDS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .addr  (prev_addr),
        .wdata (prev_wdata),
        .rdata (prev_rdata)
    );

    assign rsp_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp_valid && rsp_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            out_reg <= rsp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.status, out_reg.neighbour_id};

endmodule
`default_nettype wire

>>> sim/circular_linked_list_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_linked_list_engine_test
// Drives link commands into the ring engine and checks every response against
// an in-bench ring predictor: empty and single-entry refusals, removal of the
// head, stale anchors, repeated ids and spare op codes, with random source
// gaps and sink stalls.
// ----------------------------------------------------------------------------
module circular_linked_list_engine_test;
    import cll_pkg::*;

    localparam int unsigned ID_SPACE = ID_MAX + 1;
    localparam int unsigned WATCHDOG = 1000;
    localparam int unsigned SETTLE   = 20;
    localparam int unsigned RANDOM_COMMANDS = 1128;

    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    typedef enum logic [1:0] {
        PICK_RAW,
        PICK_WALK,
        PICK_STALE,
        PICK_FRESH
    } pick_t;

    typedef struct packed {
        logic [2:0]      op;
        pick_t           anchor_pick;
        pick_t           new_pick;
        logic [ID_W-1:0] anchor_raw;
        logic [ID_W-1:0] new_raw;
        logic [4:0]      hops;
    } cmd_plan_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // op, anchor_id, new_id
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // neighbour_id, status

    // ring predictor
    logic [ID_W-1:0]    next_of [ID_SPACE];
    logic [ID_W-1:0]    prev_of [ID_SPACE];
    logic [ID_W-1:0]    lead_id;
    logic [COUNT_W-1:0] live_count;
    bit                 on_ring [ID_SPACE];
    logic [ID_W-1:0]    stale_ids [$];
    rsp_t               due_rsp_q [$];

    cmd_plan_t   plan_q [$];
    cmd_t        cmd_in_flight;
    int unsigned hold_cycles;
    int unsigned stall_cycles;
    int unsigned src_run;
    int unsigned snk_run;
    bit          src_quiet;
    bit          snk_quiet;
    int unsigned idle_cycles;

    int unsigned op_tally [8];
    int unsigned results_checked;
    int unsigned refusals;
    int unsigned peak_count;
    int unsigned mismatches;

    circular_linked_list_engine #(
        .NUM_IDS (ID_SPACE)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void bump_count();
        if (live_count != COUNT_MAX)
            live_count = live_count + 1'b1;
        if (32'(live_count) > peak_count)
            peak_count = 32'(live_count);
    endfunction

    function automatic void splice_after(logic [ID_W-1:0] at, logic [ID_W-1:0] id);
        next_of[id]          = next_of[at];
        prev_of[id]          = at;
        prev_of[next_of[at]] = id;
        next_of[at]          = id;
        on_ring[id]          = 1'b1;
        bump_count();
    endfunction

    function automatic void unsplice(logic [ID_W-1:0] id);
        next_of[prev_of[id]] = next_of[id];
        prev_of[next_of[id]] = prev_of[id];
        if (id == lead_id)
            lead_id = next_of[id];
        if (live_count != 0)
            live_count = live_count - 1'b1;
        on_ring[id] = 1'b0;
        stale_ids.push_back(id);
        if (stale_ids.size() > 64)
            void'(stale_ids.pop_front());
    endfunction

    // advance the ring by one accepted command and queue the response it owes
    function automatic void advance_ring(cmd_t c);
        logic [ID_W-1:0] tail;
        rsp_t            owed;
        bit              answers;
        owed    = '0;
        answers = 1'b1;
        op_tally[c.op]++;
        case (c.op)
            OP_APPEND:
            begin
                answers = 1'b0;
                if (live_count == 0)
                begin
                    next_of[c.anchor_id] = c.anchor_id;
                    prev_of[c.anchor_id] = c.anchor_id;
                    lead_id              = c.anchor_id;
                end
                else
                begin
                    tail                 = prev_of[lead_id];
                    next_of[tail]        = c.anchor_id;
                    prev_of[c.anchor_id] = tail;
                    next_of[c.anchor_id] = lead_id;
                    prev_of[lead_id]     = c.anchor_id;
                end
                on_ring[c.anchor_id] = 1'b1;
                bump_count();
            end
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                if (live_count == 0)
                    owed.status = 1'b1;
                else if (c.op == OP_INS_AFTER)
                begin
                    owed.neighbour_id = next_of[c.anchor_id];
                    splice_after(c.anchor_id, c.new_id);
                end
                else
                begin
                    owed.neighbour_id = prev_of[c.anchor_id];
                    splice_after(owed.neighbour_id, c.new_id);
                end
            end
            OP_RM_NEXT, OP_RM_PREV:
            begin
                if (live_count < 2)
                    owed.status = 1'b1;
                else
                begin
                    owed.neighbour_id = (c.op == OP_RM_NEXT) ? next_of[c.anchor_id]
                                                             : prev_of[c.anchor_id];
                    unsplice(owed.neighbour_id);
                end
            end
            default:
                answers = 1'b0;
        endcase
        if (answers)
        begin
            if (owed.status)
                refusals++;
            due_rsp_q.push_back(owed);
        end
    endfunction

    // ids read by the engine are always ones whose links were written
    function automatic logic [ID_W-1:0] pick_id(pick_t how, logic [ID_W-1:0] raw,
                                                logic [4:0] hops);
        logic [ID_W-1:0] id;
        id = raw;
        if (how == PICK_STALE && stale_ids.size() != 0)
            id = stale_ids[$urandom_range(0, stale_ids.size() - 1)];
        else if ((how == PICK_STALE || how == PICK_WALK) && live_count != 0)
        begin
            id = lead_id;
            repeat (hops) id = next_of[id];
        end
        else if (how == PICK_FRESH)
            for (int t = 0; t < 8 && on_ring[id]; t++)
                id = ID_W'($urandom_range(0, ID_MAX));
        return id;
    endfunction

    function automatic cmd_t resolve_plan(cmd_plan_t p);
        cmd_t c;
        c.op        = p.op;
        c.anchor_id = pick_id(p.anchor_pick, p.anchor_raw, p.hops);
        c.new_id    = pick_id(p.new_pick, p.new_raw, p.hops + 5'd3);
        return c;
    endfunction

    function automatic cmd_plan_t plan(logic [2:0] op, pick_t ap, logic [ID_W-1:0] anchor,
                                       pick_t np, logic [ID_W-1:0] new_id);
        cmd_plan_t p;
        p.op          = op;
        p.anchor_pick = ap;
        p.new_pick    = np;
        p.anchor_raw  = anchor;
        p.new_raw     = new_id;
        p.hops        = 5'($urandom_range(0, 31));
        return p;
    endfunction

    function automatic void flag_mismatch(string what, rsp_t want, rsp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected neighbour %h status %b, got neighbour %h status %b",
                     what, want.neighbour_id, want.status, got.neighbour_id, got.status);
    endfunction

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            hold_cycles   <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_ring(cmd_in_flight);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (hold_cycles != 0)
                begin
                    hold_cycles   <= hold_cycles - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (plan_q.size() != 0)
                begin
                    cmd_in_flight = resolve_plan(plan_q.pop_front());
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, cmd_in_flight};
                    if (src_run == 0)
                    begin
                        src_quiet = ($urandom_range(0, 3) == 0);
                        src_run   = $urandom_range(8, 40);
                    end
                    src_run--;
                    hold_cycles <= src_quiet ? 0 : $urandom_range(0, 6);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned gap;
        rsp_t        got;
        rsp_t        want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_cycles  <= 2;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[12:0];
            results_checked++;
            if (due_rsp_q.size() == 0)
                flag_mismatch("unexpected response", '0, got);
            else
            begin
                want = due_rsp_q.pop_front();
                if (got.neighbour_id !== want.neighbour_id || got.status !== want.status)
                    flag_mismatch("response", want, got);
            end
            if (snk_run == 0)
            begin
                snk_quiet = ($urandom_range(0, 3) == 0);
                snk_run   = $urandom_range(8, 40);
            end
            snk_run--;
            gap = snk_quiet ? 0 : $urandom_range(0, 6);
            m_axis_tready <= (gap == 0);
            stall_cycles  <= gap;
        end
        else if (stall_cycles != 0)
        begin
            stall_cycles  <= stall_cycles - 1;
            m_axis_tready <= (stall_cycles == 1);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("circular_linked_list_engine: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned roll;
        rst_n = 1'b0;

        // empty ring, single entry, head removal, stale anchor, repeated id
        plan_q.push_back(plan(OP_RM_NEXT,    PICK_RAW, 12'hFFF, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_RM_PREV,    PICK_RAW, 12'h000, PICK_RAW, 12'hFFF));
        plan_q.push_back(plan(OP_INS_AFTER,  PICK_RAW, 12'h000, PICK_RAW, 12'hFFF));
        plan_q.push_back(plan(OP_INS_BEFORE, PICK_RAW, 12'hFFF, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_SPARE_A,    PICK_RAW, 12'hFFF, PICK_RAW, 12'hFFF));
        plan_q.push_back(plan(OP_SPARE_B,    PICK_RAW, 12'h000, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_SPARE_C,    PICK_RAW, 12'hAAA, PICK_RAW, 12'h555));
        plan_q.push_back(plan(OP_APPEND,     PICK_RAW, 12'h000, PICK_RAW, 12'hFFF));
        plan_q.push_back(plan(OP_RM_NEXT,    PICK_RAW, 12'h000, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_RM_PREV,    PICK_RAW, 12'h000, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_INS_AFTER,  PICK_RAW, 12'h000, PICK_RAW, 12'hFFF));
        plan_q.push_back(plan(OP_INS_BEFORE, PICK_RAW, 12'hFFF, PICK_RAW, 12'hAAA));
        plan_q.push_back(plan(OP_APPEND,     PICK_RAW, 12'h555, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_RM_NEXT,    PICK_RAW, 12'h555, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_RM_PREV,    PICK_RAW, 12'hAAA, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_INS_AFTER,  PICK_RAW, 12'hAAA, PICK_RAW, 12'hFFF));
        plan_q.push_back(plan(OP_RM_NEXT,    PICK_RAW, 12'h000, PICK_RAW, 12'hFFF));
        plan_q.push_back(plan(OP_RM_PREV,    PICK_RAW, 12'hFFF, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_RM_NEXT,    PICK_RAW, 12'hFFF, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_APPEND,     PICK_RAW, 12'h800, PICK_RAW, 12'h000));
        plan_q.push_back(plan(OP_INS_AFTER,  PICK_RAW, 12'h800, PICK_RAW, 12'h7FF));
        plan_q.push_back(plan(OP_INS_BEFORE, PICK_RAW, 12'h800, PICK_RAW, 12'h001));

        // mostly well-formed edits near the head, some stale anchors and repeats
        repeat (RANDOM_COMMANDS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                plan_q.push_back(plan(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)),
                                      PICK_RAW, ID_W'($urandom_range(0, ID_MAX)),
                                      PICK_RAW, ID_W'($urandom_range(0, ID_MAX))));
            else if (roll < 13)
                plan_q.push_back(plan(OP_APPEND, PICK_FRESH, ID_W'($urandom_range(0, ID_MAX)),
                                      PICK_RAW, ID_W'($urandom_range(0, ID_MAX))));
            else if (roll < 53)
                plan_q.push_back(plan($urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE,
                                      ($urandom_range(0, 9) == 0) ? PICK_STALE : PICK_WALK, '0,
                                      ($urandom_range(0, 11) == 0) ? PICK_WALK : PICK_FRESH,
                                      ID_W'($urandom_range(0, ID_MAX))));
            else
                plan_q.push_back(plan($urandom_range(0, 1) ? OP_RM_NEXT : OP_RM_PREV,
                                      (roll >= 95) ? PICK_STALE : PICK_WALK, '0,
                                      PICK_RAW, ID_W'($urandom_range(0, ID_MAX))));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk); while (plan_q.size() != 0 || s_axis_tvalid);
        repeat (6)
            plan_q.push_back(plan($urandom_range(0, 1) ? OP_RM_NEXT : OP_RM_PREV,
                                  PICK_WALK, '0, PICK_RAW, ID_W'($urandom_range(0, ID_MAX))));
        repeat (2)
            plan_q.push_back(plan(OP_INS_AFTER, PICK_WALK, '0, PICK_FRESH,
                                  ID_W'($urandom_range(0, ID_MAX))));

        do @(negedge clk);
        while (plan_q.size() != 0 || s_axis_tvalid || due_rsp_q.size() != 0);
        repeat (SETTLE) @(posedge clk);

        while (due_rsp_q.size() != 0)
            flag_mismatch("missing response", due_rsp_q.pop_front(), '0);

        $display("commands: %0d append, %0d insert, %0d remove, %0d spare op",
                 op_tally[OP_APPEND], op_tally[OP_INS_AFTER] + op_tally[OP_INS_BEFORE],
                 op_tally[OP_RM_NEXT] + op_tally[OP_RM_PREV],
                 op_tally[OP_SPARE_A] + op_tally[OP_SPARE_B] + op_tally[OP_SPARE_C]);
        $display("responses checked: %0d, refused: %0d, peak ring count: %0d, mismatches: %0d",
                 results_checked, refusals, peak_count, mismatches);
        if (mismatches == 0)
            $display("circular_linked_list_engine: match");
        else
            $display("circular_linked_list_engine: mismatch");
        $finish;
    end

endmodule
